// ===== rtl/core/c2p_pkg.sv =====
// Shared types, widths and constants for the cartesian-to-polar converter.
// Holds the arctangent table function. Used by every file under rtl/core.
package c2p_pkg;

  // Field widths at the ports
  localparam int IN_W  = 24;
  localparam int MOD_W = 24;
  localparam int ANG_W = 18;

  // Datapath: input scaled by 2^8 (20 fraction bits), room for CORDIC growth
  localparam int FRAC_EXT = 8;
  localparam int XW       = 36;
  localparam int ZW       = 32;

  // Micro-rotations: configured count, capped at the table length
  localparam int ITERATIONS = 16;
  localparam int TABLE_LEN  = 24;
  localparam int NUM_ROT    = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int TIDX_W     = $clog2(TABLE_LEN);

  // Gain compensation 1/K in Q30, multiply split into two partial products
  localparam int            KW        = 30;
  localparam logic [KW-1:0] INV_GAIN  = 30'h26DD3B6A;
  localparam int            MSPLIT    = 17;
  localparam int            HI_W      = XW - 1 - MSPLIT;
  localparam int            PHW       = HI_W + KW;
  localparam int            PLW       = MSPLIT + KW;
  localparam int            SW        = XW + KW;
  localparam int            MOD_SHIFT = 38;
  localparam int            MWW       = SW - MOD_SHIFT;

  // Angle output: z in Q30 rounded to Q16, clamped to +/- pi/2
  localparam int                ANG_SHIFT = 14;
  localparam logic signed [ZW:0] ANG_RND  = 33'sd8192;
  localparam logic signed [ZW:0] ANG_HI   = 33'sd102944;
  localparam logic signed [ZW:0] ANG_LO   = -33'sd102944;

  // One vector in flight through the rotator
  typedef struct packed {
    logic                 zero;  // imaginary part was zero: no rotation
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } c2p_vec_t;

  // atan(2^-i) * 2^30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input logic [TIDX_W-1:0] idx);
    logic signed [ZW-1:0] val;
    begin
      unique case (idx)
        5'd0:    val = 32'sh3243F6A8;
        5'd1:    val = 32'sh1DAC6705;
        5'd2:    val = 32'sh0FADBAFC;
        5'd3:    val = 32'sh07F56EA6;
        5'd4:    val = 32'sh03FEAB76;
        5'd5:    val = 32'sh01FFD55B;
        5'd6:    val = 32'sh00FFFAAA;
        5'd7:    val = 32'sh007FFF55;
        5'd8:    val = 32'sh003FFFEA;
        5'd9:    val = 32'sh001FFFFD;
        5'd10:   val = 32'sh000FFFFF;
        5'd11:   val = 32'sh0007FFFF;
        5'd12:   val = 32'sh0003FFFF;
        5'd13:   val = 32'sh0001FFFF;
        5'd14:   val = 32'sh0000FFFF;
        5'd15:   val = 32'sh00007FFF;
        5'd16:   val = 32'sh00003FFF;
        5'd17:   val = 32'sh00001FFF;
        5'd18:   val = 32'sh00000FFF;
        5'd19:   val = 32'sh000007FF;
        5'd20:   val = 32'sh000003FF;
        5'd21:   val = 32'sh000001FF;
        5'd22:   val = 32'sh000000FF;
        5'd23:   val = 32'sh0000007F;
        default: val = '0;
      endcase
      return val;
    end
  endfunction

endpackage

// ===== rtl/core/c2p_rotator.sv =====
// Pipelined CORDIC vectoring rotator: one register stage per micro-rotation.
// Depends on c2p_pkg for widths, the vector struct and the arctangent table.
module c2p_rotator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  c2p_pkg::c2p_vec_t in_vec,
  output logic              out_valid,
  input  logic              out_ready,
  output c2p_pkg::c2p_vec_t out_vec
);

  logic              v_r       [c2p_pkg::NUM_ROT];
  c2p_pkg::c2p_vec_t d_r       [c2p_pkg::NUM_ROT];
  c2p_pkg::c2p_vec_t d_nxt     [c2p_pkg::NUM_ROT];
  logic              stage_rdy [c2p_pkg::NUM_ROT];
  logic              src_v     [c2p_pkg::NUM_ROT];
  c2p_pkg::c2p_vec_t src_d     [c2p_pkg::NUM_ROT];
  logic              down_rdy  [c2p_pkg::NUM_ROT];

  for (genvar i = 0; i < c2p_pkg::NUM_ROT; i++) begin : g_stage
    logic signed [c2p_pkg::XW-1:0] xs;
    logic signed [c2p_pkg::XW-1:0] ys;
    logic signed [c2p_pkg::ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign src_v[i] = in_valid;
      assign src_d[i] = in_vec;
    end else begin : g_mid
      assign src_v[i] = v_r[i-1];
      assign src_d[i] = d_r[i-1];
    end

    if (i == c2p_pkg::NUM_ROT - 1) begin : g_last
      assign down_rdy[i] = out_ready;
    end else begin : g_inner
      assign down_rdy[i] = stage_rdy[i+1];
    end

    assign stage_rdy[i] = !v_r[i] || down_rdy[i];

    assign xs  = src_d[i].x >>> i;
    assign ys  = src_d[i].y >>> i;
    assign ang = c2p_pkg::atan_q30(c2p_pkg::TIDX_W'(i));

    // Rotate toward the x axis; y sign picks the direction
    always_comb begin
      d_nxt[i] = src_d[i];
      if (!src_d[i].zero) begin
        if (!src_d[i].y[c2p_pkg::XW-1]) begin
          d_nxt[i].x = src_d[i].x + ys;
          d_nxt[i].y = src_d[i].y - xs;
          d_nxt[i].z = src_d[i].z + ang;
        end else begin
          d_nxt[i].x = src_d[i].x - ys;
          d_nxt[i].y = src_d[i].y + xs;
          d_nxt[i].z = src_d[i].z - ang;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (stage_rdy[i]) begin
        v_r[i] <= src_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (stage_rdy[i] && src_v[i]) begin
        d_r[i] <= d_nxt[i];
      end
    end
  end

  assign in_ready  = stage_rdy[0];
  assign out_valid = v_r[c2p_pkg::NUM_ROT-1];
  assign out_vec   = d_r[c2p_pkg::NUM_ROT-1];

endmodule

// ===== rtl/core/c2p_scale.sv =====
// Output stages: gain compensation multiply, angle rounding, modulus saturation.
// Depends on c2p_pkg for widths, the vector struct and rounding constants.
module c2p_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  c2p_pkg::c2p_vec_t                 in_vec,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [c2p_pkg::MOD_W-1:0]  out_modulus,
  output logic signed [c2p_pkg::ANG_W-1:0]  out_angle
);

  // Stage 1: partial products and angle
  logic                              m1_v_r;
  logic        [c2p_pkg::PHW-1:0]    p_hi_r, p_hi_nxt;
  logic        [c2p_pkg::PLW-1:0]    p_lo_r, p_lo_nxt;
  logic        [c2p_pkg::MOD_W-1:0]  direct_r, direct_nxt;
  logic                              zero_r;
  logic signed [c2p_pkg::ANG_W-1:0]  ang_r, ang_nxt;
  logic        [c2p_pkg::XW-2:0]     xc;
  logic signed [c2p_pkg::ZW:0]       z_rnd;
  logic signed [c2p_pkg::ZW:0]       z_sh;

  // Stage 2: result register
  logic                              out_v_r;
  logic        [c2p_pkg::MOD_W-1:0]  mod_r, mod_nxt;
  logic signed [c2p_pkg::ANG_W-1:0]  ang_out_r;
  logic        [c2p_pkg::SW-1:0]     sum;
  logic        [c2p_pkg::MWW-1:0]    mod_wide;

  logic m1_rdy, m2_rdy;

  assign m2_rdy   = !out_v_r || out_ready;
  assign m1_rdy   = !m1_v_r || m2_rdy;
  assign in_ready = m1_rdy;

  always_comb begin
    xc         = in_vec.x[c2p_pkg::XW-1] ? '0 : in_vec.x[c2p_pkg::XW-2:0];
    p_hi_nxt   = c2p_pkg::PHW'(xc[c2p_pkg::XW-2:c2p_pkg::MSPLIT]) *
                 c2p_pkg::PHW'(c2p_pkg::INV_GAIN);
    p_lo_nxt   = c2p_pkg::PLW'(xc[c2p_pkg::MSPLIT-1:0]) *
                 c2p_pkg::PLW'(c2p_pkg::INV_GAIN);
    // Unrotated vector still holds |re| * 2^8
    direct_nxt = in_vec.x[c2p_pkg::FRAC_EXT +: c2p_pkg::MOD_W];
    z_rnd      = {in_vec.z[c2p_pkg::ZW-1], in_vec.z} + c2p_pkg::ANG_RND;
    z_sh       = z_rnd >>> c2p_pkg::ANG_SHIFT;
    if (in_vec.zero) begin
      ang_nxt = '0;
    end else if (z_sh > c2p_pkg::ANG_HI) begin
      ang_nxt = c2p_pkg::ANG_HI[c2p_pkg::ANG_W-1:0];
    end else if (z_sh < c2p_pkg::ANG_LO) begin
      ang_nxt = c2p_pkg::ANG_LO[c2p_pkg::ANG_W-1:0];
    end else begin
      ang_nxt = z_sh[c2p_pkg::ANG_W-1:0];
    end
  end

  always_comb begin
    sum = (c2p_pkg::SW'(p_hi_r) << c2p_pkg::MSPLIT) + c2p_pkg::SW'(p_lo_r) +
          (c2p_pkg::SW'(1) << (c2p_pkg::MOD_SHIFT - 1));
    mod_wide = sum[c2p_pkg::SW-1:c2p_pkg::MOD_SHIFT];
    if (zero_r) begin
      mod_nxt = direct_r;
    end else if (|mod_wide[c2p_pkg::MWW-1:c2p_pkg::MOD_W]) begin
      mod_nxt = '1;
    end else begin
      mod_nxt = mod_wide[c2p_pkg::MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (m1_rdy) begin
        m1_v_r <= in_valid;
      end
      if (m2_rdy) begin
        out_v_r <= m1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m1_rdy && in_valid) begin
      p_hi_r   <= p_hi_nxt;
      p_lo_r   <= p_lo_nxt;
      direct_r <= direct_nxt;
      zero_r   <= in_vec.zero;
      ang_r    <= ang_nxt;
    end
    if (m2_rdy && m1_v_r) begin
      mod_r     <= mod_nxt;
      ang_out_r <= ang_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_modulus = mod_r;
  assign out_angle   = ang_out_r;

endmodule

// ===== rtl/core/cartesian_to_polar.sv =====
// Top level of the cartesian-to-polar converter: input stage and wiring.
// Depends on c2p_pkg, c2p_rotator and c2p_scale.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one complex sample per transfer:
//   in_real_part and in_imag_part, signed Q12.12.
//   Result channel (out_valid/out_ready) returns one transfer per input:
//   out_modulus, unsigned Q12.12, rounded and saturated, and out_angle,
//   signed Q2.16 radians within +/- pi/2 (atan2 of im over |re|).
//   A sample with zero imaginary part returns |re| exactly and angle zero.
// Pipeline: 19 register stages (1 input stage, 16 micro-rotation stages,
//   2 gain/rounding stages), in that order.
// Throughput: one sample per cycle while out_ready stays high; every stage
//   is a register with its own valid bit, so a new sample enters each cycle.
// Reset (rst_n low, synchronous) drops every sample in flight; no clearing
//   pass, the block accepts input on the first cycle after reset.
// Stall: when out_ready is low the result holds; stages behind it keep
//   filling empty slots, and in_ready falls only once the whole pipe is full.
module cartesian_to_polar (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [c2p_pkg::IN_W-1:0]   in_real_part,
  input  logic signed [c2p_pkg::IN_W-1:0]   in_imag_part,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [c2p_pkg::MOD_W-1:0]  out_modulus,
  output logic signed [c2p_pkg::ANG_W-1:0]  out_angle
);

  logic                          s0_v_r;
  c2p_pkg::c2p_vec_t             s0_d_r, s0_d_nxt;
  logic                          s0_rdy;
  logic signed [c2p_pkg::XW-1:0] re_ext;
  logic signed [c2p_pkg::XW-1:0] im_ext;
  logic signed [c2p_pkg::XW-1:0] re_abs;

  logic              rot_in_ready;
  logic              rot_out_valid;
  c2p_pkg::c2p_vec_t rot_out_vec;
  logic              scl_in_ready;

  // Fold the vector into the right half plane and scale up by 2^8.
  // The wide datapath keeps |most negative real| exact.
  always_comb begin
    re_ext        = {{(c2p_pkg::XW - c2p_pkg::IN_W){in_real_part[c2p_pkg::IN_W-1]}},
                     in_real_part};
    im_ext        = {{(c2p_pkg::XW - c2p_pkg::IN_W){in_imag_part[c2p_pkg::IN_W-1]}},
                     in_imag_part};
    re_abs        = re_ext[c2p_pkg::XW-1] ? -re_ext : re_ext;
    s0_d_nxt.zero = (in_imag_part == '0);
    s0_d_nxt.x    = re_abs <<< c2p_pkg::FRAC_EXT;
    s0_d_nxt.y    = im_ext <<< c2p_pkg::FRAC_EXT;
    s0_d_nxt.z    = '0;
  end

  // Input stage: advance when empty or when the rotator takes its contents
  assign s0_rdy   = !s0_v_r || rot_in_ready;
  assign in_ready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_valid) begin
      s0_d_r <= s0_d_nxt;
    end
  end

  c2p_rotator u_rotator (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_v_r),
    .in_ready  (rot_in_ready),
    .in_vec    (s0_d_r),
    .out_valid (rot_out_valid),
    .out_ready (scl_in_ready),
    .out_vec   (rot_out_vec)
  );

  c2p_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (rot_out_valid),
    .in_ready    (scl_in_ready),
    .in_vec      (rot_out_vec),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_modulus (out_modulus),
    .out_angle   (out_angle)
  );

endmodule

// ===== bench/c2p_polar_checker.sv =====
// Result checker for the cartesian-to-polar converter: predicts each transfer and compares.
// Depends on c2p_pkg for the port widths and the micro-rotation count.
module c2p_polar_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [c2p_pkg::IN_W-1:0]   in_real_part,
  input  logic signed [c2p_pkg::IN_W-1:0]   in_imag_part,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic        [c2p_pkg::MOD_W-1:0]  out_modulus,
  input  logic signed [c2p_pkg::ANG_W-1:0]  out_angle,
  output int                                mismatches,
  output int                                outstanding
);

  localparam longint ANGLE_LIMIT = 102944;
  localparam longint MOD_SAT     = 64'hFFFFFF;
  localparam longint INV_K_Q30   = 64'h26DD3B6A;

  typedef struct {
    logic signed [c2p_pkg::IN_W-1:0]  re;
    logic signed [c2p_pkg::IN_W-1:0]  im;
    logic        [c2p_pkg::MOD_W-1:0] modulus;
    logic signed [c2p_pkg::ANG_W-1:0] angle;
  } polar_t;

  polar_t expected_polar[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Vectoring CORDIC on (|re|, im) with 20 fraction bits and a Q30 angle accumulator
  function automatic polar_t polar_of(input logic signed [c2p_pkg::IN_W-1:0] re,
                                      input logic signed [c2p_pkg::IN_W-1:0] im);
    longint          ax, x, y, z, xs, ys, step, a;
    longint unsigned m;
    int              i;
    polar_t          p;
    ax = (re < 0) ? -longint'(re) : longint'(re);
    if (im == 0) begin
      m = ax;
      a = 0;
    end else begin
      x = ax <<< 8;
      y = longint'(im) <<< 8;
      z = 0;
      for (i = 0; i < c2p_pkg::ITERATIONS && i < 24; i++) begin
        case (i)
          0:       step = 64'h3243F6A8;
          1:       step = 64'h1DAC6705;
          2:       step = 64'h0FADBAFC;
          3:       step = 64'h07F56EA6;
          4:       step = 64'h03FEAB76;
          5:       step = 64'h01FFD55B;
          6:       step = 64'h00FFFAAA;
          7:       step = 64'h007FFF55;
          8:       step = 64'h003FFFEA;
          9:       step = 64'h001FFFFD;
          default: step = (64'h1 << (30 - i)) - 1;  // atan(2^-i) truncates to this from 10 on
        endcase
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += step;
        end else begin
          x -= ys;
          y += xs;
          z -= step;
        end
      end
      if (x < 0) x = 0;
      m = ($unsigned(x) * INV_K_Q30 + (64'd1 << 37)) >> 38;
      a = (z + 8192) >>> 14;
    end
    if (m > MOD_SAT) m = MOD_SAT;
    if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
    if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
    p.re      = re;
    p.im      = im;
    p.modulus = m[c2p_pkg::MOD_W-1:0];
    p.angle   = a[c2p_pkg::ANG_W-1:0];
    return p;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    polar_t want;
    if (rst_n) begin
      // check the result side first: an input transfer in this cycle cannot be out yet
      if (out_valid && out_ready) begin
        if (expected_polar.size() == 0) begin
          report($sformatf("result with nothing pending: modulus=%0d angle=%0d",
                           out_modulus, out_angle));
        end else begin
          want = expected_polar.pop_front();
          if (out_modulus !== want.modulus)
            report($sformatf("modulus %0d, expected %0d (re=%0d im=%0d)",
                             out_modulus, want.modulus, want.re, want.im));
          if (out_angle !== want.angle)
            report($sformatf("angle %0d, expected %0d (re=%0d im=%0d)",
                             out_angle, want.angle, want.re, want.im));
        end
      end
      if (in_valid && in_ready)
        expected_polar.push_back(polar_of(in_real_part, in_imag_part));
    end
    outstanding = expected_polar.size();
  end

endmodule

// ===== bench/tb_cartesian_to_polar.sv =====
// Testbench top for the cartesian-to-polar converter: clock, reset, stimulus and verdict.
// Depends on c2p_pkg, the cartesian_to_polar RTL and c2p_polar_checker.
module tb_cartesian_to_polar;

  localparam int IN_W = c2p_pkg::IN_W;

  // Extremes of a Q12.12 component
  localparam logic signed [IN_W-1:0] COMP_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] COMP_MIN = {1'b1, {(IN_W-1){1'b0}}};

  // Pipe is 19 deep; the tail wait after the last drain shows any stray result
  localparam int DRAIN_CYCLES = 40;
  // Watchdog limit, far above the length of the slowest run
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_PER_PHASE = 280;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [IN_W-1:0]            in_real_part;
  logic signed [IN_W-1:0]            in_imag_part;
  logic                              out_valid;
  logic                              out_ready;
  logic        [c2p_pkg::MOD_W-1:0]  out_modulus;
  logic signed [c2p_pkg::ANG_W-1:0]  out_angle;

  int mismatches;
  int outstanding;
  int cycles;

  // Idle odds in percent, changed per phase
  int send_idle_pct;
  int recv_idle_pct;

  cartesian_to_polar uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_real_part (in_real_part),
    .in_imag_part (in_imag_part),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_modulus  (out_modulus),
    .out_angle    (out_angle)
  );

  c2p_polar_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_real_part (in_real_part),
    .in_imag_part (in_imag_part),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_modulus  (out_modulus),
    .out_angle    (out_angle),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: drive out_ready at random on every falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Pick one component: full-range random in three of eight draws, with small magnitudes,
  // scaled values, exact zero, near-extreme values and the extremes mixed in
  function automatic logic signed [IN_W-1:0] pick_component();
    logic signed [IN_W-1:0] v;
    case ($urandom_range(7))
      0, 1, 2: v = IN_W'($urandom);
      3:       v = IN_W'(int'($urandom_range(255)) - 128);
      4: begin
        v = IN_W'($urandom);
        v = v >>> $urandom_range(20);
      end
      5: begin
        case ($urandom_range(4))
          0:       v = COMP_MAX;
          1:       v = COMP_MIN;
          2:       v = 1;
          3:       v = -1;
          default: v = 0;
        endcase
      end
      6:       v = 0;
      default: v = $urandom_range(1) ? IN_W'(COMP_MAX - $urandom_range(15))
                                     : IN_W'(COMP_MIN + $urandom_range(15));
    endcase
    return v;
  endfunction

  // Present one sample and hold it until the transfer; called and returns at a falling edge
  task automatic send_sample(input logic signed [IN_W-1:0] re,
                             input logic signed [IN_W-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_real_part <= re;
    in_imag_part <= im;
    // in_valid is high at this edge, so in_ready alone decides the transfer
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    int n;
    for (n = 0; n < count; n++)
      send_sample(pick_component(), pick_component());
  endtask

  initial begin
    // Drive every input to a known value before the first edge
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_real_part  = '0;
    in_imag_part  = '0;
    out_ready     = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 60;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero imaginary part returns |re| with no rotation
    send_sample(0, 0);
    send_sample(COMP_MAX, 0);
    send_sample(COMP_MIN, 0);
    send_sample(-1, 0);
    send_sample(1, 0);
    // Directed: on the imaginary axis the angle sits at the clamp
    send_sample(0, COMP_MAX);
    send_sample(0, COMP_MIN);
    send_sample(0, 1);
    send_sample(0, -1);
    // Directed: corners give the largest modulus
    send_sample(COMP_MAX, COMP_MAX);
    send_sample(COMP_MIN, COMP_MIN);
    send_sample(COMP_MIN, COMP_MAX);
    send_sample(COMP_MAX, COMP_MIN);
    // Directed: small and mixed-sign samples; a negative real part folds onto the right half plane
    send_sample(-1, -1);
    send_sample(-1, 1);
    send_sample(1, 1);
    send_sample(COMP_MIN, 1);
    send_sample(1, COMP_MIN);
    send_sample(24'sd4096, -24'sd4096);
    send_sample(-24'sd12288, 24'sd16384);

    // Phase one: sender rarely idles, receiver stalls a lot
    send_random(RANDOM_PER_PHASE);

    // Hold off once until the pipe is empty
    drain_results();

    // Phase two: sender idles a lot, receiver rarely stalls
    send_idle_pct = 60;
    recv_idle_pct = 7;
    send_random(RANDOM_PER_PHASE);

    // Phase three: no idling on either side, full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
